>>> rtl/hbo_pkg.sv
// ----------------------------------------------------------------------------
// hbo_pkg
// Shared codes, field widths and control/status bundles of the histogram
// binner.
// ----------------------------------------------------------------------------
package hbo_pkg;

  localparam int CMD_W      = 2;
  localparam int SMP_W      = 32;
  localparam int SEL_W      = 9;
  localparam int STS_W      = 2;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int BINS_CFG_W = 9;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // result status
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_BAD_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD_SEL   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS       = 2'd2;

  localparam logic [SMP_W-1:0]      RANGE_LOW_RST  = 32'h0000_0000;
  localparam logic [SMP_W-1:0]      RANGE_HIGH_RST = 32'h0001_0000;
  localparam logic [BINS_CFG_W-1:0] BINS_RST       = 9'd256;

  typedef struct packed {
    logic load_in;
    logic clr_init;
    logic clr_step;
    logic eval;
    logic mul;
    logic div_start;
    logic set_idx;
    logic rd_issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             bad;
    logic             clr_last;
    logic             div_busy;
  } dp_stat_t;

endpackage

>>> rtl/hbo_in_if.sv
// ----------------------------------------------------------------------------
// hbo_in_if
// Command channel: valid/ready handshake with command, sample and bin select.
// ----------------------------------------------------------------------------
interface hbo_in_if;
  logic                                valid;
  logic                                ready;
  logic [hbo_pkg::CMD_W-1:0]           command;
  logic signed [hbo_pkg::SMP_W-1:0]    sample;
  logic [hbo_pkg::SEL_W-1:0]           bin_select;

  modport source (output valid, command, sample, bin_select, input ready);
  modport sink   (input valid, command, sample, bin_select, output ready);
endinterface

>>> rtl/hbo_out_if.sv
// ----------------------------------------------------------------------------
// hbo_out_if
// Result channel: valid/ready handshake with status, bin and counts.
// ----------------------------------------------------------------------------
interface hbo_out_if;
  logic                              valid;
  logic                              ready;
  logic [hbo_pkg::STS_W-1:0]         status;
  logic [hbo_pkg::SEL_W-1:0]         bin_index;
  logic [hbo_pkg::OUT_CNT_W-1:0]     bin_count;
  logic [hbo_pkg::OUT_CNT_W-1:0]     total_count;
  logic [hbo_pkg::OUT_CNT_W-1:0]     in_range_count;

  modport source (output valid, status, bin_index, bin_count, total_count,
                  in_range_count, input ready);
  modport sink   (input valid, status, bin_index, bin_count, total_count,
                  in_range_count, output ready);
endinterface

>>> rtl/hbo_div.sv
// ----------------------------------------------------------------------------
// hbo_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in Q_W bits, so only Q_W steps are run.
// ----------------------------------------------------------------------------
module hbo_div #(
  parameter int Q_W = 9,
  parameter int D_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [D_W+Q_W-1:0] dividend,
  input  logic [D_W-1:0]     divisor,
  output logic               busy,
  output logic [Q_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [D_W-1:0]   rem_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;

  always_comb begin
    trial = {rem_r, low_r[Q_W-1]};
    fits  = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(Q_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[D_W+Q_W-1:Q_W];
      low_r <= dividend[Q_W-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits D_W bits either way
      rem_r <= fits ? D_W'(diff) : D_W'(trial);
      low_r <= low_r << 1;
      quo_r <= (quo_r << 1) | Q_W'(fits);
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> rtl/hbo_ctrl.sv
// ----------------------------------------------------------------------------
// hbo_ctrl
// Sequencer: clearing sweep, command decode, insert steps, read steps and
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module hbo_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  hbo_pkg::dp_stat_t  stat,
  output hbo_pkg::ctrl_cmd_t cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DGO   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_IDX   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_WB    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       reply_r, reply_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_free  = !out_valid_r || out_ready;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = reply_r ? S_WB : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.cmd)
          hbo_pkg::CMD_INSERT: state_nxt = S_EVAL;
          hbo_pkg::CMD_READ:   state_nxt = S_IDX;
          hbo_pkg::CMD_CLEAR: begin
            cmd.clr_init = 1'b1;
            reply_nxt    = 1'b1;
            state_nxt    = S_CLR;
          end
          hbo_pkg::CMD_NOP:    state_nxt = S_WB;
          default:             state_nxt = S_WB;
        endcase
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.bad ? S_WB : S_DGO;
      end
      S_DGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_IDX;
        end
      end
      S_IDX: begin
        cmd.set_idx = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_WB;
      end
      S_WB: begin
        // hold until the output register can take the beat
        if (out_free) begin
          cmd.finish = 1'b1;
          reply_nxt  = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/hbo_dp.sv
// ----------------------------------------------------------------------------
// hbo_dp
// Datapath: configuration registers, range checks, bin arithmetic, count
// memory, saturating totals and the output register.
// ----------------------------------------------------------------------------
module hbo_dp #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hbo_pkg::ctrl_cmd_t                  cmd,
  output hbo_pkg::dp_stat_t                   stat,
  input  logic [hbo_pkg::CMD_W-1:0]           in_command,
  input  logic signed [hbo_pkg::SMP_W-1:0]    in_sample,
  input  logic [hbo_pkg::SEL_W-1:0]           in_bin_select,
  input  logic                                cfg_we,
  input  logic [hbo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hbo_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [hbo_pkg::STS_W-1:0]           out_status,
  output logic [hbo_pkg::SEL_W-1:0]           out_bin_index,
  output logic [hbo_pkg::OUT_CNT_W-1:0]       out_bin_count,
  output logic [hbo_pkg::OUT_CNT_W-1:0]       out_total_count,
  output logic [hbo_pkg::OUT_CNT_W-1:0]       out_in_range_count
);

  localparam int DEPTH = MAX_BINS + 2;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int BW    = $clog2(MAX_BINS + 1);
  localparam int SW    = (IDX_W > hbo_pkg::SEL_W) ? IDX_W : hbo_pkg::SEL_W;
  localparam int D_W   = hbo_pkg::SMP_W;
  localparam int P_W   = D_W + BW;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
  endfunction

  // configuration
  logic signed [D_W-1:0]              lo_r, hi_r;
  logic [hbo_pkg::BINS_CFG_W-1:0]     bins_cfg_r;

  // captured item
  logic [hbo_pkg::CMD_W-1:0]          cmd_r;
  logic signed [D_W-1:0]              sample_r;
  logic [hbo_pkg::SEL_W-1:0]          sel_r;

  // insert arithmetic
  logic                               bad_r, under_r, over_r, zspan_r;
  logic [D_W-1:0]                     off_r, span_r;
  logic [P_W-1:0]                     prod_r;
  logic [BW-1:0]                      quo;
  logic                               div_busy;

  logic [IDX_W-1:0]                   idx_r, idx_nxt;
  logic                               sel_bad_r, sel_bad;
  logic [BW-1:0]                      eff_bins;
  logic [IDX_W-1:0]                   bins_p1;

  // count store
  logic [COUNT_BITS-1:0]              mem [DEPTH];
  logic [COUNT_BITS-1:0]              rdata_r;
  logic [IDX_W-1:0]                   clr_addr_r;
  logic                               mem_we;
  logic [IDX_W-1:0]                   mem_waddr;
  logic [COUNT_BITS-1:0]              mem_wdata;
  logic [COUNT_BITS-1:0]              cnt_inc;

  logic [COUNT_BITS-1:0]              tot_r, tot_nxt;
  logic [COUNT_BITS-1:0]              inr_r, inr_nxt;

  logic [hbo_pkg::STS_W-1:0]          status_nxt;
  logic [hbo_pkg::SEL_W-1:0]          bin_index_nxt;
  logic [COUNT_BITS-1:0]              bin_count_nxt;
  logic [hbo_pkg::STS_W-1:0]          status_r;
  logic [hbo_pkg::SEL_W-1:0]          bin_index_r;
  logic [hbo_pkg::OUT_CNT_W-1:0]      bin_count_r, total_r, in_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r       <= hbo_pkg::RANGE_LOW_RST;
      hi_r       <= hbo_pkg::RANGE_HIGH_RST;
      bins_cfg_r <= hbo_pkg::BINS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbo_pkg::CFG_RANGE_LOW:  lo_r       <= cfg_wdata;
        hbo_pkg::CFG_RANGE_HIGH: hi_r       <= cfg_wdata;
        hbo_pkg::CFG_BINS:       bins_cfg_r <= cfg_wdata[hbo_pkg::BINS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bins_cfg_r == '0) begin
      eff_bins = BW'(1);
    end else if (int'(bins_cfg_r) > MAX_BINS) begin
      eff_bins = BW'(MAX_BINS);
    end else begin
      eff_bins = BW'(bins_cfg_r);
    end
    bins_p1 = IDX_W'(eff_bins) + IDX_W'(1);
    sel_bad = (SW'(sel_r) > SW'(bins_p1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r    <= in_command;
      sample_r <= in_sample;
      sel_r    <= in_bin_select;
    end
    if (cmd.eval) begin
      bad_r   <= (hi_r < lo_r);
      under_r <= (sample_r < lo_r);
      over_r  <= (sample_r > hi_r);
      zspan_r <= (hi_r == lo_r);
      // both differences are non-negative whenever they are used
      off_r   <= D_W'(sample_r - lo_r);
      span_r  <= D_W'(hi_r - lo_r);
    end
    if (cmd.mul) begin
      prod_r <= P_W'(off_r) * P_W'(eff_bins);
    end
  end

  hbo_div #(
    .Q_W (BW),
    .D_W (D_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (span_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    if (cmd_r == hbo_pkg::CMD_READ) begin
      idx_nxt = sel_bad ? '0 : IDX_W'(sel_r);
    end else if (under_r) begin
      idx_nxt = '0;
    end else if (over_r) begin
      idx_nxt = bins_p1;
    end else if (zspan_r) begin
      idx_nxt = IDX_W'(1);
    end else if (quo >= eff_bins) begin
      idx_nxt = IDX_W'(eff_bins);
    end else begin
      idx_nxt = IDX_W'(quo) + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_idx) begin
      idx_r     <= idx_nxt;
      sel_bad_r <= sel_bad;
    end
  end

  // result, totals and memory write for the finishing beat; clearing-sweep write
  always_comb begin
    cnt_inc       = sat_inc(rdata_r);
    tot_nxt       = tot_r;
    inr_nxt       = inr_r;
    status_nxt    = hbo_pkg::STS_OK;
    bin_index_nxt = '0;
    bin_count_nxt = '0;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr_r;
    mem_wdata     = '0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end
    case (cmd_r)
      hbo_pkg::CMD_INSERT: begin
        if (bad_r) begin
          status_nxt = hbo_pkg::STS_BAD_RANGE;
        end else begin
          bin_index_nxt = hbo_pkg::SEL_W'(idx_r);
          bin_count_nxt = cnt_inc;
          tot_nxt       = sat_inc(tot_r);
          if (!under_r && !over_r) begin
            inr_nxt = sat_inc(inr_r);
          end
          if (cmd.finish) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = cnt_inc;
          end
        end
      end
      hbo_pkg::CMD_READ: begin
        bin_index_nxt = sel_r;
        if (sel_bad_r) begin
          status_nxt = hbo_pkg::STS_BAD_SEL;
        end else begin
          bin_count_nxt = rdata_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_issue) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      tot_r      <= '0;
      inr_r      <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= stat.clr_last ? '0 : clr_addr_r + IDX_W'(1);
      end
      if (cmd.clr_init) begin
        tot_r <= '0;
        inr_r <= '0;
      end else if (cmd.finish) begin
        tot_r <= tot_nxt;
        inr_r <= inr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r    <= status_nxt;
      bin_index_r <= bin_index_nxt;
      bin_count_r <= hbo_pkg::OUT_CNT_W'(bin_count_nxt);
      total_r     <= hbo_pkg::OUT_CNT_W'(tot_nxt);
      in_range_r  <= hbo_pkg::OUT_CNT_W'(inr_nxt);
    end
  end

  always_comb begin
    stat          = '0;
    stat.cmd      = cmd_r;
    stat.bad      = bad_r;
    stat.clr_last = (clr_addr_r == IDX_W'(DEPTH - 1));
    stat.div_busy = div_busy;
  end

  assign out_status         = status_r;
  assign out_bin_index      = bin_index_r;
  assign out_bin_count      = bin_count_r;
  assign out_total_count    = total_r;
  assign out_in_range_count = in_range_r;

endmodule

>>> rtl/histogram_binner_with_overflow.sv
// ----------------------------------------------------------------------------
// histogram_binner_with_overflow
// Equal-width histogram of signed Q16.16 samples with underflow and overflow
// bins. Each command beat gives one result beat. For an insert, the bin
// index comes from a restoring divider that produces one quotient bit per
// cycle, after a range-check stage and a multiply stage, and the count is a
// read-modify-write of the count memory. A clear command, and reset, run a
// sweep over all MAX_BINS + 2 entries of the count memory, one entry per
// cycle; no command is accepted during the sweep, configuration writes are.
// One command is worked at a time; a finished result waits in the output
// register while the next command is accepted and worked.
// ----------------------------------------------------------------------------
module histogram_binner_with_overflow #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hbo_in_if.sink                          in_ch,
  hbo_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hbo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  hbo_pkg::ctrl_cmd_t cmd;
  hbo_pkg::dp_stat_t  stat;

  hbo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hbo_dp #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_command         (in_ch.command),
    .in_sample          (in_ch.sample),
    .in_bin_select      (in_ch.bin_select),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_status         (out_ch.status),
    .out_bin_index      (out_ch.bin_index),
    .out_bin_count      (out_ch.bin_count),
    .out_total_count    (out_ch.total_count),
    .out_in_range_count (out_ch.in_range_count)
  );

  // a result is loaded only when the output register is free or draining
  a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending beat");

  // a new result beat appears only after a finish step
  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.finish))
    else $error("result valid without finish");

  // no command is taken while the count memory is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ch.ready)
    else $error("command accepted during clearing sweep");

  // the divider is never restarted while it is working
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the histogram binner. A driver feeds command beats
// from a queue and a shadow histogram predicts each result beat; a monitor
// compares every result field against the oldest prediction. Both sides idle
// at random and the range and bin registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import hbo_pkg::*;

  localparam int MAX_BINS      = 256;
  localparam int COUNT_BITS    = 32;
  localparam int SETTLE_CYCLES = MAX_BINS + 16;
  localparam int MAX_GAP       = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 125;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [SMP_W-1:0] sample;
    logic [SEL_W-1:0]        bin_select;
  } bin_cmd_t;

  typedef struct packed {
    logic [STS_W-1:0]     status;
    logic [SEL_W-1:0]     bin_index;
    logic [OUT_CNT_W-1:0] bin_count;
    logic [OUT_CNT_W-1:0] total_count;
    logic [OUT_CNT_W-1:0] in_range_count;
  } bin_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hbo_in_if  in_ch ();
  hbo_out_if out_ch ();

  histogram_binner_with_overflow #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow registers and counters of the histogram
  logic signed [SMP_W-1:0] lim_low;
  logic signed [SMP_W-1:0] lim_high;
  logic [BINS_CFG_W-1:0]   bin_setting;
  logic [OUT_CNT_W-1:0]    bin_tally [0:MAX_BINS+1];
  logic [OUT_CNT_W-1:0]    total_tally;
  logic [OUT_CNT_W-1:0]    in_range_tally;

  bin_cmd_t    pending_cmds [$];
  bin_result_t awaited_results [$];
  int          mismatch_count = 0;
  bit          quiet_phase = 1'b0;

  function automatic int effective_bins();
    if (bin_setting == 0) return 1;
    if (bin_setting > MAX_BINS) return MAX_BINS;
    return int'(bin_setting);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat_bump(input logic [OUT_CNT_W-1:0] n);
    return (&n) ? n : n + 1'b1;
  endfunction

  function automatic int draw_gap();
    return quiet_phase ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  // Update the shadow histogram with one command and return its result beat.
  function automatic bin_result_t bin_command_result(input bin_cmd_t c);
    bin_result_t r;
    longint      lo;
    longint      hi;
    longint      v;
    longint      span;
    int          nbins;
    int          idx;
    r     = '0;
    nbins = effective_bins();
    lo    = lim_low;
    hi    = lim_high;
    v     = $signed(c.sample);
    case (c.command)
      CMD_INSERT: begin
        if (hi < lo) begin
          r.status = STS_BAD_RANGE;
        end else begin
          if (v < lo) begin
            idx = 0;
          end else if (v > hi) begin
            idx = nbins + 1;
          end else begin
            span = hi - lo;
            if (span == 0) idx = 1;
            else idx = 1 + int'(((v - lo) * nbins) / span);
            // the top edge lands in the last regular bin
            if (idx > nbins) idx = nbins;
          end
          bin_tally[idx] = sat_bump(bin_tally[idx]);
          if (idx != 0 && idx != nbins + 1) in_range_tally = sat_bump(in_range_tally);
          total_tally = sat_bump(total_tally);
          r.status    = STS_OK;
          r.bin_index = SEL_W'(idx);
          r.bin_count = bin_tally[idx];
        end
      end
      CMD_READ: begin
        r.bin_index = c.bin_select;
        if (c.bin_select > nbins + 1) begin
          r.status = STS_BAD_SEL;
        end else begin
          r.status    = STS_OK;
          r.bin_count = bin_tally[c.bin_select];
        end
      end
      CMD_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        total_tally    = '0;
        in_range_tally = '0;
      end
      default: ;  // unused command leaves everything as it is
    endcase
    r.total_count    = total_tally;
    r.in_range_count = in_range_tally;
    return r;
  endfunction

  function automatic bin_cmd_t random_bin_command();
    bin_cmd_t c;
    longint   lo;
    longint   hi;
    longint   roll;
    int       nbins;
    int       pick;
    nbins        = effective_bins();
    lo           = lim_low;
    hi           = lim_high;
    c.sample     = $urandom;
    c.bin_select = SEL_W'($urandom_range(0, 511));
    pick         = $urandom_range(0, 99);
    if (pick < 60) c.command = CMD_INSERT;
    else if (pick < 88) c.command = CMD_READ;
    else if (pick < 92) c.command = CMD_CLEAR;
    else c.command = CMD_NOP;
    if (c.command == CMD_INSERT) begin
      case ($urandom_range(0, 9))
        0: c.sample = $urandom;
        1: c.sample = lim_low;
        2: c.sample = lim_high;
        3: c.sample = lim_low - 1;
        4: c.sample = lim_high + 1;
        5: c.sample = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        default: begin
          roll = $urandom;
          if (hi >= lo) c.sample = SMP_W'(lo + roll % (hi - lo + 1));
        end
      endcase
    end else if (c.command == CMD_READ) begin
      case ($urandom_range(0, 5))
        0: c.bin_select = SEL_W'($urandom_range(0, 511));
        1: c.bin_select = SEL_W'(nbins + 1);
        2: c.bin_select = SEL_W'(nbins + 2);
        default: c.bin_select = SEL_W'($urandom_range(0, nbins + 1));
      endcase
    end
    return c;
  endfunction

  function automatic void note_mismatch(input string what, input bin_result_t want,
                                        input bin_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $write("%0t: %s: expected sts=%0d bin=%0d cnt=%0d tot=%0d inr=%0d",
             $time, what, want.status, want.bin_index, want.bin_count,
             want.total_count, want.in_range_count);
      $display(", got sts=%0d bin=%0d cnt=%0d tot=%0d inr=%0d",
               got.status, got.bin_index, got.bin_count, got.total_count,
               got.in_range_count);
    end
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [SMP_W-1:0] value,
                           input logic [SEL_W-1:0] sel);
    bin_cmd_t c;
    c.command    = op;
    c.sample     = value;
    c.bin_select = sel;
    pending_cmds.push_back(c);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_RANGE_LOW:  lim_low = value;
      CFG_RANGE_HIGH: lim_high = value;
      CFG_BINS:       bin_setting = value[BINS_CFG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setup(input logic [SMP_W-1:0] lo, input logic [SMP_W-1:0] hi,
                             input logic [BINS_CFG_W-1:0] nb);
    write_register(CFG_RANGE_LOW, lo);
    write_register(CFG_RANGE_HIGH, hi);
    write_register(CFG_BINS, CFG_DATA_W'(nb));
    @(negedge clk);
  endtask

  task automatic pick_random_setup();
    logic signed [SMP_W-1:0] a;
    logic signed [SMP_W-1:0] b;
    logic [BINS_CFG_W-1:0]   nb;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        a = 32'sh8000_0000;
        b = 32'sh7fff_ffff;
      end
      1: begin
        // high below low: inserts get rejected
        a = $urandom_range(1, 32'h7fff_ffff);
        b = a - $urandom_range(1, 65536);
      end
      2: b = a;
      3: begin
        b = a + $urandom_range(0, 32'h0004_0000);
        if (b < a) b = 32'sh7fff_ffff;
      end
      default: if (a > b) {a, b} = {b, a};
    endcase
    case ($urandom_range(0, 9))
      0: nb = 9'd0;
      1: nb = 9'd1;
      2: nb = 9'd256;
      3: nb = 9'h1ff;
      4, 5, 6: nb = BINS_CFG_W'($urandom_range(2, 8));
      default: nb = BINS_CFG_W'($urandom_range(0, 511));
    endcase
    apply_setup(a, b, nb);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_ch.valid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // command driver
  bin_cmd_t next_cmd;
  bin_cmd_t took_cmd;
  int       send_wait;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.command    <= CMD_NOP;
      in_ch.sample     <= '0;
      in_ch.bin_select <= '0;
      send_wait = 0;
      total_tally    = '0;
      in_range_tally = '0;
      foreach (bin_tally[i]) bin_tally[i] = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        took_cmd.command    = in_ch.command;
        took_cmd.sample     = in_ch.sample;
        took_cmd.bin_select = in_ch.bin_select;
        awaited_results.push_back(bin_command_result(took_cmd));
        send_wait = draw_gap();
      end
      // hold the beat while it is stalled
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          next_cmd = pending_cmds.pop_front();
          in_ch.command    <= next_cmd.command;
          in_ch.sample     <= next_cmd.sample;
          in_ch.bin_select <= next_cmd.bin_select;
          in_ch.valid      <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  bin_result_t seen_result;
  bin_result_t want_result;
  int          take_wait;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_result.status         = out_ch.status;
        seen_result.bin_index      = out_ch.bin_index;
        seen_result.bin_count      = out_ch.bin_count;
        seen_result.total_count    = out_ch.total_count;
        seen_result.in_range_count = out_ch.in_range_count;
        if (awaited_results.size() == 0) begin
          note_mismatch("result beat with nothing outstanding", '0, seen_result);
        end else begin
          want_result = awaited_results.pop_front();
          if (seen_result.status !== want_result.status ||
              seen_result.bin_index !== want_result.bin_index ||
              seen_result.bin_count !== want_result.bin_count ||
              seen_result.total_count !== want_result.total_count ||
              seen_result.in_range_count !== want_result.in_range_count)
            note_mismatch("result beat differs", want_result, seen_result);
        end
        take_wait = draw_gap();
      end
      if (take_wait > 0) begin
        take_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_RANGE_LOW;
    cfg_wdata        = '0;
    lim_low          = RANGE_LOW_RST;
    lim_high         = RANGE_HIGH_RST;
    bin_setting      = BINS_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // range [0, 1.0] with 256 bins: edges, out-of-range, field extremes
    @(negedge clk);
    queue_cmd(CMD_INSERT, 32'h0000_0000, 9'd0);
    queue_cmd(CMD_INSERT, 32'h0001_0000, 9'd0);
    queue_cmd(CMD_INSERT, 32'h0000_8000, 9'd0);
    queue_cmd(CMD_INSERT, 32'hffff_ffff, 9'd0);
    queue_cmd(CMD_INSERT, 32'h0001_0001, 9'd0);
    queue_cmd(CMD_INSERT, 32'h8000_0000, 9'h1ff);
    queue_cmd(CMD_INSERT, 32'h7fff_ffff, 9'h1ff);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd0);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd129);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd256);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd257);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd258);
    queue_cmd(CMD_READ, 32'hffff_ffff, 9'h1ff);
    queue_cmd(CMD_NOP, 32'h1234_5678, 9'd1);
    queue_cmd(CMD_CLEAR, 32'h0000_0000, 9'd0);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd129);
    wait_until_drained();

    // high below low
    apply_setup(32'h0001_0000, 32'h0000_0000, 9'd4);
    queue_cmd(CMD_INSERT, 32'h0000_8000, 9'd0);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd5);
    wait_until_drained();

    // zero span, and a bin setting of zero
    apply_setup(32'h0003_0000, 32'h0003_0000, 9'd0);
    queue_cmd(CMD_INSERT, 32'h0003_0000, 9'd0);
    queue_cmd(CMD_INSERT, 32'h0002_ffff, 9'd0);
    queue_cmd(CMD_INSERT, 32'h0003_0001, 9'd0);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd2);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd3);
    wait_until_drained();

    // widest span, bin setting above the maximum
    apply_setup(32'h8000_0000, 32'h7fff_ffff, 9'h1ff);
    queue_cmd(CMD_INSERT, 32'h8000_0000, 9'd0);
    queue_cmd(CMD_INSERT, 32'h7fff_ffff, 9'd0);
    queue_cmd(CMD_INSERT, 32'h0000_0000, 9'd0);
    queue_cmd(CMD_READ, 32'h0000_0000, 9'd257);
    wait_until_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick_random_setup();
      quiet_phase = (ph % 4 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) pending_cmds.push_back(random_bin_command());
      wait_until_drained();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
